// ===== sv/mhfe_pkg.sv =====
// Shared types and character constants for the mail header field extractor.
package mhfe_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  // One result beat
  typedef struct packed {
    logic [7:0] value_byte;
    logic       is_end;
    logic       found;
  } result_t;

  // Results raised by one input byte, first in r0
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // ASCII upper case to lower case, everything else untouched
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== sv/mail_header_field_extractor_unit.sv =====
// Header field value extractor: takes one header byte per beat and returns the value of the
// first line whose start matches the configured key (case-insensitive), plus one continuation
// line, then an end beat with the found flag when the byte marked last arrives. One input beat
// is accepted every clock unless input stall is raised; all parsing is a single combinational
// step on the parser state registers. A byte can raise up to two result beats (a value byte and
// the end beat), which go into a four-entry queue that drains one beat per clock unless the
// output is stalled; input stall is raised while fewer than two queue slots are free. The user
// must write key registers only while the block is idle; the block does not enforce this.
module mail_header_field_extractor_unit #(
  parameter int MAX_KEY   = 16,
  parameter int MAX_VALUE = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  value_byte_o,
  output logic        is_end_o,
  output logic        found_o
);

  logic [63:0] key_low_q, key_high_q;
  logic [4:0]  key_len_q;
  logic        room;
  logic        accept;

  mhfe_pkg::push_t   push;
  mhfe_pkg::result_t out_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mhfe_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        mhfe_pkg::REG_KEY_HIGH: key_high_q <= cfg_data_i;
        mhfe_pkg::REG_KEY_LEN:  key_len_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  mhfe_parser #(
    .MAX_KEY   (MAX_KEY),
    .MAX_VALUE (MAX_VALUE)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .key_i       ({key_high_q, key_low_q}),
    .key_len_i   (key_len_q),
    .push_o      (push)
  );

  mhfe_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .room_o      (room)
  );

  assign value_byte_o = out_data.value_byte;
  assign is_end_o     = out_data.is_end;
  assign found_o      = out_data.found;

  // Checks
  a_push_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt != 2'd0 |-> accept)
    else $error("result raised without an accepted beat");

  a_last_gives_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |-> push.cnt != 2'd0)
    else $error("last byte produced no end beat");

  a_value_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_end_o |-> !found_o)
    else $error("found flag on a value beat");

endmodule

// ===== sv/mhfe_parser.sv =====
// Header parsing state machine: key match, value and continuation capture.
module mhfe_parser #(
  parameter int MAX_KEY   = 16,
  parameter int MAX_VALUE = 512
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic [127:0]    key_i,
  input  logic [4:0]      key_len_i,
  output mhfe_pkg::push_t push_o
);

  localparam int VcW = $clog2(MAX_VALUE + 1);

  localparam logic [2:0] M_MATCH    = 3'd0;
  localparam logic [2:0] M_SKIPLINE = 3'd1;
  localparam logic [2:0] M_SKIP2    = 3'd2;
  localparam logic [2:0] M_VALUE    = 3'd3;
  localparam logic [2:0] M_GAP      = 3'd4;
  localparam logic [2:0] M_PEEK     = 3'd5;
  localparam logic [2:0] M_CONT     = 3'd6;
  localparam logic [2:0] M_DONE     = 3'd7;

  logic [2:0]     mode_q, mode_d;
  logic [4:0]     key_pos_q, key_pos_d;
  logic [1:0]     lb_q, lb_d;
  logic           skip_q, skip_d;
  logic [VcW-1:0] vcount_q, vcount_d;

  logic [4:0] eff_len;
  logic [7:0] key_byte;
  logic       emit_req;
  logic       emit_ok;
  logic [2:0] mode_mid;

  // Effective key length: zero counts as one, saturate at MAX_KEY
  always_comb begin
    eff_len = key_len_i;
    if (key_len_i == 5'd0) begin
      eff_len = 5'd1;
    end else if (key_len_i > 5'(MAX_KEY)) begin
      eff_len = 5'(MAX_KEY);
    end
  end

  assign key_byte = key_i[{key_pos_q[3:0], 3'b000} +: 8];

  // Next state for one byte
  always_comb begin
    mode_mid  = mode_q;
    key_pos_d = key_pos_q;
    lb_d      = lb_q;
    skip_d    = skip_q;
    emit_req  = 1'b0;
    unique case (mode_q)
      M_MATCH, M_SKIPLINE: begin
        if (mode_q == M_MATCH &&
            mhfe_pkg::fold(data_byte_i) == mhfe_pkg::fold(key_byte)) begin
          key_pos_d = key_pos_q + 5'd1;
          lb_d      = 2'd0;
          if (key_pos_d >= eff_len) begin
            mode_mid = M_SKIP2;
            skip_d   = 1'b0;
          end
        end else begin
          mode_mid = M_SKIPLINE;
          if (data_byte_i == mhfe_pkg::CH_CR) begin
            lb_d = 2'd1;
          end else if (data_byte_i == mhfe_pkg::CH_LF && lb_q == 2'd1) begin
            mode_mid  = M_MATCH;
            key_pos_d = 5'd0;
            lb_d      = 2'd2;
          end else begin
            lb_d = 2'd0;
          end
        end
      end
      M_SKIP2: begin
        skip_d = 1'b1;
        if (skip_q) begin
          mode_mid = M_VALUE;
        end
      end
      M_VALUE, M_CONT: begin
        if (data_byte_i == mhfe_pkg::CH_CR || data_byte_i == mhfe_pkg::CH_LF) begin
          mode_mid = (mode_q == M_VALUE) ? M_GAP : M_DONE;
        end else begin
          emit_req = 1'b1;
        end
      end
      M_GAP: begin
        mode_mid = M_PEEK;
      end
      M_PEEK: begin
        if (data_byte_i == mhfe_pkg::CH_SP) begin
          emit_req = 1'b1;
          mode_mid = M_CONT;
        end else begin
          mode_mid = M_DONE;
        end
      end
      default: begin
        mode_mid = M_DONE;
      end
    endcase
  end

  // Value length limit
  assign emit_ok  = emit_req && (vcount_q < VcW'(MAX_VALUE));
  assign vcount_d = emit_ok ? vcount_q + VcW'(1) : vcount_q;
  assign mode_d   = mode_mid;

  // Result beats for this byte: optional value byte, then optional end
  always_comb begin
    push_o = '0;
    if (accept_i) begin
      if (emit_ok) begin
        push_o.r0.value_byte = data_byte_i;
        if (last_byte_i) begin
          push_o.r1.is_end = 1'b1;
          push_o.r1.found  = (mode_mid >= M_SKIP2);
          push_o.cnt       = 2'd2;
        end else begin
          push_o.cnt = 2'd1;
        end
      end else if (last_byte_i) begin
        push_o.r0.is_end = 1'b1;
        push_o.r0.found  = (mode_mid >= M_SKIP2);
        push_o.cnt       = 2'd1;
      end
    end
  end

  // State registers, cleared after every end beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_MATCH;
      key_pos_q <= 5'd0;
      lb_q      <= 2'd2;
      skip_q    <= 1'b0;
      vcount_q  <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        mode_q    <= M_MATCH;
        key_pos_q <= 5'd0;
        lb_q      <= 2'd2;
        skip_q    <= 1'b0;
        vcount_q  <= '0;
      end else begin
        mode_q    <= mode_d;
        key_pos_q <= key_pos_d;
        lb_q      <= lb_d;
        skip_q    <= skip_d;
        vcount_q  <= vcount_d;
      end
    end
  end

  // Checks
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> push_o.r1.is_end && !push_o.r0.is_end)
    else $error("two beats but end beat not last");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> mode_q == M_MATCH && key_pos_q == 5'd0 &&
      vcount_q == '0)
    else $error("state not cleared after end of buffer");

  a_value_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcount_q <= VcW'(MAX_VALUE))
    else $error("value count beyond limit");

endmodule

// ===== sv/mhfe_out_fifo.sv =====
// Four-entry result queue: up to two beats in and, unless stalled, one beat out a cycle.
module mhfe_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhfe_pkg::push_t   push_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output mhfe_pkg::result_t out_data_o,
  output logic              room_o
);

  mhfe_pkg::result_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] count_q;
  logic       pop;

  assign out_valid_o = (count_q != 3'd0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Room for the worst case of two beats
  assign room_o      = (count_q <= 3'd2);

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 2'd0;
      rd_q    <= 2'd0;
      count_q <= 3'd0;
    end else begin
      wr_q    <= wr_q + push_i.cnt;
      rd_q    <= rd_q + {1'b0, pop};
      count_q <= count_q + {1'b0, push_i.cnt} - {2'b00, pop};
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room_o)
    else $error("push into full queue");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("queue level out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 3'd4 |-> (wr_q - rd_q) == count_q[1:0])
    else $error("pointers disagree with level");

endmodule
